// File: rtl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared sizes, types and helpers of the heightmap vertex normal block.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_W    = 1024;
  localparam int MAX_H    = 1024;
  localparam int CFG_W    = 11;
  localparam int COL_W    = $clog2(MAX_W);
  localparam int ROWV_W   = $clog2(MAX_H);
  localparam int DIM_W    = $clog2((MAX_W > MAX_H ? MAX_W : MAX_H) + 1);
  localparam int SLOT_W   = 2;
  localparam int ADDR_W   = $clog2(3 * MAX_W);
  localparam int HGT_W    = 16;
  localparam int SUM_W    = 19;
  localparam int USQ_W    = 38;
  localparam int SQ_W     = 38;
  localparam int SQ_LO_W  = 19;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int K_W      = 16;
  localparam int K2_W     = 32;
  localparam int PART_W   = K2_W + SQ_LO_W;
  localparam int CMP_W    = 71;
  localparam int FRAC_SH  = 30;
  localparam int RES_W    = 15;
  localparam int BIT_W    = 4;
  localparam int NRM_W    = 16;
  localparam int UNIT_ONE = 16384;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic [HGT_W-1:0]  data;
  } hvn_wr_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
  } hvn_rd_t;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + {1'b0, k};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage

// File: rtl/hvn_store.sv
// ----------------------------------------------------------------------------
// hvn_store
// Ring of three sample rows in one synchronous RAM, one write and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module hvn_store (
  input  logic                        clk,
  input  hvn_pkg::hvn_wr_t            wr,
  input  hvn_pkg::hvn_rd_t            rd,
  output logic [hvn_pkg::HGT_W-1:0]   rdata
);

  logic [hvn_pkg::HGT_W-1:0] mem [3 * hvn_pkg::MAX_W];
  logic [hvn_pkg::ADDR_W-1:0] waddr;
  logic [hvn_pkg::ADDR_W-1:0] raddr;

  assign waddr = hvn_pkg::ADDR_W'(wr.slot) * hvn_pkg::ADDR_W'(hvn_pkg::MAX_W)
               + hvn_pkg::ADDR_W'(wr.col);
  assign raddr = hvn_pkg::ADDR_W'(rd.slot) * hvn_pkg::ADDR_W'(hvn_pkg::MAX_W)
               + hvn_pkg::ADDR_W'(rd.col);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hvn_norm.sv
// ----------------------------------------------------------------------------
// hvn_norm
// Normalizes a summed vector to Q1.14, rounded to nearest, by a bit-serial
// search per component with a split wide multiply.
// ----------------------------------------------------------------------------
module hvn_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [hvn_pkg::SUM_W-1:0]  sx,
  input  logic signed [hvn_pkg::SUM_W-1:0]  sy,
  input  logic signed [hvn_pkg::SUM_W-1:0]  sz,
  output logic                              done,
  output logic [hvn_pkg::NRM_W-1:0]         nx,
  output logic [hvn_pkg::NRM_W-1:0]         ny,
  output logic [hvn_pkg::NRM_W-1:0]         nz
);

  typedef enum logic [5:0] {
    N_IDLE = 6'b000001,
    N_SQ   = 6'b000010,
    N_K2   = 6'b000100,
    N_PLO  = 6'b001000,
    N_PHI  = 6'b010000,
    N_CMP  = 6'b100000
  } nstate_t;

  nstate_t state;
  logic signed [hvn_pkg::SUM_W-1:0] sv [3];
  logic [hvn_pkg::USQ_W-1:0]  usq [3];
  logic [hvn_pkg::SQ_W-1:0]   sq;
  logic [1:0]                 comp;
  logic [hvn_pkg::BIT_W-1:0]  bitpos;
  logic [hvn_pkg::RES_W-1:0]  cur;
  logic [hvn_pkg::K2_W-1:0]   k2;
  logic [hvn_pkg::PART_W-1:0] plo;
  logic [hvn_pkg::PART_W-1:0] phi;
  logic [hvn_pkg::NRM_W-1:0]  res [3];

  logic [hvn_pkg::SUM_W-1:0]  uabs;
  logic [hvn_pkg::RES_W-1:0]  cand;
  logic [hvn_pkg::K_W-1:0]    kval;
  logic [hvn_pkg::CMP_W-1:0]  lhs;
  logic [hvn_pkg::CMP_W-1:0]  rhs;
  logic [hvn_pkg::RES_W-1:0]  cur_next;
  logic [hvn_pkg::NRM_W-1:0]  mag;

  always_comb begin
    uabs = sv[comp][hvn_pkg::SUM_W-1] ? hvn_pkg::SUM_W'(-sv[comp])
                                      : hvn_pkg::SUM_W'(sv[comp]);
    cand = cur | (hvn_pkg::RES_W'(1) << bitpos);
    kval = {cand, 1'b0} - hvn_pkg::K_W'(1);
    lhs  = hvn_pkg::CMP_W'(usq[comp]) << hvn_pkg::FRAC_SH;
    rhs  = hvn_pkg::CMP_W'(plo) + (hvn_pkg::CMP_W'(phi) << hvn_pkg::SQ_LO_W);
    cur_next = cur;
    if (rhs <= lhs && cand <= hvn_pkg::RES_W'(hvn_pkg::UNIT_ONE)) begin
      cur_next = cand;
    end
    mag = hvn_pkg::NRM_W'(cur_next);
  end

  assign done = (state == N_CMP) && (bitpos == '0) && (comp == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            sv[0] <= sx;
            sv[1] <= sy;
            sv[2] <= sz;
            sq    <= '0;
            comp  <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          usq[comp] <= hvn_pkg::USQ_W'(uabs) * hvn_pkg::USQ_W'(uabs);
          sq        <= sq + hvn_pkg::SQ_W'(uabs) * hvn_pkg::SQ_W'(uabs);
          if (comp == 2'd2) begin
            comp   <= 2'd0;
            bitpos <= hvn_pkg::BIT_W'(hvn_pkg::RES_W - 1);
            cur    <= '0;
            state  <= N_K2;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        N_K2: begin
          k2    <= hvn_pkg::K2_W'(kval) * hvn_pkg::K2_W'(kval);
          state <= N_PLO;
        end
        N_PLO: begin
          plo   <= hvn_pkg::PART_W'(k2) * hvn_pkg::PART_W'(sq[hvn_pkg::SQ_LO_W-1:0]);
          state <= N_PHI;
        end
        N_PHI: begin
          phi   <= hvn_pkg::PART_W'(k2) * hvn_pkg::PART_W'(sq[hvn_pkg::SQ_W-1:hvn_pkg::SQ_LO_W]);
          state <= N_CMP;
        end
        N_CMP: begin
          if (bitpos == '0) begin
            res[comp] <= sv[comp][hvn_pkg::SUM_W-1] ? -mag : mag;
            cur       <= '0;
            bitpos    <= hvn_pkg::BIT_W'(hvn_pkg::RES_W - 1);
            if (comp == 2'd2) begin
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_K2;
            end
          end else begin
            cur    <= cur_next;
            bitpos <= bitpos - hvn_pkg::BIT_W'(1);
            state  <= N_K2;
          end
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

  assign nx = res[0];
  assign ny = res[1];
  assign nz = res[2];

endmodule

// File: rtl/heightmap_vertex_normals.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// Streams heightmap samples into a three-row ring and gives one unit vertex
// normal per vertex, one row behind the input, with drain beats for the
// last row.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata = height, tuser = action
//  m_axis    out  tdata = normal_x/y/z, column, row_index; tlast = last
//  cfg       in   grid_width (index 0), grid_height (index 1)
//
// A beat that yields no normal leaves the block in idle. Otherwise seven RAM
// reads fetch the neighborhood, a sum step follows, then the shared normalize
// unit squares the three components one at a time and searches 15 result bits
// per component, each bit through states N_K2, N_PLO, N_PHI and N_CMP.
// Reset clears the counters, state and output valid and sets both grid sizes to 2; the row RAM needs no clearing.
// A finished normal waits in the output register while the next beat enters.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // height[15:0]
  input  logic [0:0]                  s_axis_tuser,   // action[0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [71:0]                 m_axis_tdata,   // normal_x, normal_y,
                                                      // normal_z, column,
                                                      // row_index, zero pad
  output logic                        m_axis_tlast,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [hvn_pkg::CFG_W-1:0]   cfg_data
);

  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic       ACT_SAMPLE      = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_NORM = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  function automatic logic [hvn_pkg::DIM_W-1:0] clamp_dim(
    input logic [hvn_pkg::CFG_W-1:0] v, input int maxv);
    logic [hvn_pkg::DIM_W-1:0] r;
    r = hvn_pkg::DIM_W'(v);
    if (v < hvn_pkg::CFG_W'(2)) begin
      r = hvn_pkg::DIM_W'(2);
    end else if (v > hvn_pkg::CFG_W'(maxv)) begin
      r = hvn_pkg::DIM_W'(maxv);
    end
    return r;
  endfunction

  state_t state;
  logic [hvn_pkg::CFG_W-1:0]  grid_width;
  logic [hvn_pkg::CFG_W-1:0]  grid_height;
  logic [hvn_pkg::COL_W-1:0]  col_count;
  logic [hvn_pkg::DIM_W-1:0]  row_count;
  logic [hvn_pkg::COL_W-1:0]  drain_count;
  logic [hvn_pkg::SLOT_W-1:0] slot;

  logic [hvn_pkg::COL_W-1:0]  job_col;
  logic [hvn_pkg::ROWV_W-1:0] job_row;
  logic                       job_last;
  logic [hvn_pkg::HGT_W-1:0]  job_hh;
  logic [hvn_pkg::SLOT_W-1:0] job_slot;
  logic [2:0]                 rd_cnt;
  logic [hvn_pkg::HGT_W-1:0]  vals [7];

  logic [hvn_pkg::NRM_W-1:0]  out_x, out_y, out_z;
  logic [hvn_pkg::COL_W-1:0]  out_col;
  logic [hvn_pkg::ROWV_W-1:0] out_row;
  logic                       out_last;

  logic [hvn_pkg::DIM_W-1:0]  w, h;
  logic                       accept, is_sample, smp_ok, drn_ok, drn_fin;
  hvn_pkg::hvn_wr_t           wr;
  hvn_pkg::hvn_rd_t           rd;
  logic [hvn_pkg::HGT_W-1:0]  rdata;

  logic                       e00, e10, e01, e11;
  logic signed [hvn_pkg::SUM_W-1:0] sx, sy, sz;
  logic                       norm_start, norm_done;
  logic [hvn_pkg::NRM_W-1:0]  nx, ny, nz;

  assign w = clamp_dim(grid_width, hvn_pkg::MAX_W);
  assign h = clamp_dim(grid_height, hvn_pkg::MAX_H);

  assign s_axis_tready = (state == ST_IDLE) && !cfg_we;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_sample     = (s_axis_tuser[0] == ACT_SAMPLE);
  assign smp_ok        = (row_count < h) && (hvn_pkg::DIM_W'(col_count) < w);
  assign drn_ok        = (row_count >= h) && (hvn_pkg::DIM_W'(drain_count) < w);
  assign drn_fin       = (hvn_pkg::DIM_W'(drain_count) + hvn_pkg::DIM_W'(1) >= w);

  always_comb begin
    wr.en   = accept && is_sample && smp_ok;
    wr.slot = slot;
    wr.col  = col_count;
    wr.data = s_axis_tdata;
    case (rd_cnt)
      3'd0:    rd.slot = hvn_pkg::slot_add(job_slot, 2'd1);
      3'd1:    rd.slot = hvn_pkg::slot_add(job_slot, 2'd1);
      3'd2:    rd.slot = hvn_pkg::slot_add(job_slot, 2'd1);
      3'd3:    rd.slot = hvn_pkg::slot_add(job_slot, 2'd2);
      3'd4:    rd.slot = hvn_pkg::slot_add(job_slot, 2'd2);
      3'd5:    rd.slot = hvn_pkg::slot_add(job_slot, 2'd2);
      default: rd.slot = job_slot;
    endcase
    case (rd_cnt)
      3'd0, 3'd3, 3'd6: rd.col = job_col - hvn_pkg::COL_W'(1);
      3'd2, 3'd5:       rd.col = job_col + hvn_pkg::COL_W'(1);
      default:          rd.col = job_col;
    endcase
  end

  hvn_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  always_comb begin
    logic signed [hvn_pkg::SUM_W-1:0] a, b, c, d, e, f, g, hh;
    a  = hvn_pkg::SUM_W'(signed'(vals[0]));
    b  = hvn_pkg::SUM_W'(signed'(vals[1]));
    c  = hvn_pkg::SUM_W'(signed'(vals[2]));
    d  = hvn_pkg::SUM_W'(signed'(vals[3]));
    e  = hvn_pkg::SUM_W'(signed'(vals[4]));
    f  = hvn_pkg::SUM_W'(signed'(vals[5]));
    g  = hvn_pkg::SUM_W'(signed'(vals[6]));
    hh = hvn_pkg::SUM_W'(signed'(job_hh));
    e00 = (job_col != '0) && (job_row != '0);
    e10 = (hvn_pkg::DIM_W'(job_col) + hvn_pkg::DIM_W'(1) < w) && (job_row != '0);
    e01 = (job_col != '0) && (hvn_pkg::DIM_W'(job_row) + hvn_pkg::DIM_W'(1) < h);
    e11 = (hvn_pkg::DIM_W'(job_col) + hvn_pkg::DIM_W'(1) < w)
       && (hvn_pkg::DIM_W'(job_row) + hvn_pkg::DIM_W'(1) < h);
    sx = (e00 ? a - b : '0) + (e10 ? b - c : '0) + (e01 ? d - e : '0) + (e11 ? e - f : '0);
    sz = (e00 ? a - d : '0) + (e10 ? b - e : '0) + (e01 ? d - g : '0) + (e11 ? e - hh : '0);
    sy = hvn_pkg::SUM_W'({e00, 8'd0}) + hvn_pkg::SUM_W'({e10, 8'd0})
       + hvn_pkg::SUM_W'({e01, 8'd0}) + hvn_pkg::SUM_W'({e11, 8'd0});
  end

  assign norm_start = (state == ST_SUM);

  hvn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sx    (sx),
    .sy    (sy),
    .sz    (sz),
    .done  (norm_done),
    .nx    (nx),
    .ny    (ny),
    .nz    (nz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      grid_width    <= hvn_pkg::CFG_W'(2);
      grid_height   <= hvn_pkg::CFG_W'(2);
      col_count     <= '0;
      row_count     <= '0;
      drain_count   <= '0;
      slot          <= '0;
      rd_cnt        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH) begin
          grid_width <= cfg_data;
        end else if (cfg_index == REG_GRID_HEIGHT) begin
          grid_height <= cfg_data;
        end
        col_count   <= '0;
        row_count   <= '0;
        drain_count <= '0;
        slot        <= '0;
      end
      case (state)
        ST_IDLE: begin
          rd_cnt <= '0;
          if (accept && is_sample && smp_ok) begin
            job_col  <= col_count;
            job_row  <= hvn_pkg::ROWV_W'(row_count - hvn_pkg::DIM_W'(1));
            job_last <= 1'b0;
            job_hh   <= s_axis_tdata;
            job_slot <= slot;
            if (row_count != '0) begin
              state <= ST_RD;
            end
            if (hvn_pkg::DIM_W'(col_count) + hvn_pkg::DIM_W'(1) >= w) begin
              col_count <= '0;
              row_count <= row_count + hvn_pkg::DIM_W'(1);
              slot      <= hvn_pkg::slot_add(slot, 2'd1);
            end else begin
              col_count <= col_count + hvn_pkg::COL_W'(1);
            end
          end else if (accept && !is_sample && drn_ok) begin
            job_col  <= drain_count;
            job_row  <= hvn_pkg::ROWV_W'(h - hvn_pkg::DIM_W'(1));
            job_last <= drn_fin;
            job_slot <= slot;
            state    <= ST_RD;
            if (drn_fin) begin
              drain_count <= '0;
              row_count   <= '0;
              col_count   <= '0;
              slot        <= '0;
            end else begin
              drain_count <= drain_count + hvn_pkg::COL_W'(1);
            end
          end
        end
        ST_RD: begin
          if (rd_cnt != '0) begin
            vals[rd_cnt - 3'd1] <= rdata;
          end
          if (rd_cnt == 3'd7) begin
            state <= ST_SUM;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        ST_SUM: begin
          state <= ST_NORM;
        end
        ST_NORM: begin
          if (norm_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_x    <= nx;
            out_y    <= ny;
            out_z    <= nz;
            out_col  <= job_col;
            out_row  <= job_row;
            out_last <= job_last;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {4'd0, out_row, out_col, out_z, out_y, out_x};
  assign m_axis_tlast = out_last;

endmodule
